// File: src/sled_pkg.sv
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types, command codes and lookup functions for the status pixel and
// caps lamp pattern controller.
// ----------------------------------------------------------------------------
package sled_pkg;

    // input beat: a timer tick or a command
    typedef struct packed {
        logic       operation;
        logic [3:0] command;
    } item_t;

    // result beat
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       caps_lamp_on;
        logic       pixel_refresh;
    } result_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [3:0] MODE_CAPS_USB  = 4'd0;
    localparam logic [3:0] MODE_CAPS_BLE  = 4'd1;
    localparam logic [3:0] MODE_USB       = 4'd2;
    localparam logic [3:0] MODE_BT_SEARCH = 4'd3;
    localparam logic [3:0] MODE_BT_CONN   = 4'd4;
    localparam logic [3:0] MODE_RAINBOW   = 4'd5;
    localparam logic [3:0] MODE_ERROR     = 4'd6;
    localparam logic [3:0] CMD_BRIGHTER   = 4'd7;
    localparam logic [3:0] CMD_DIMMER     = 4'd8;

    localparam logic [2:0] LEVEL_INDEX_RESET = 3'd2;
    localparam logic [7:0] BLINK_TICKS       = 8'd250;

    // brightness level 2^(i+1)-1
    function automatic logic [7:0] level_of(input logic [2:0] idx);
        logic [8:0] full;
        full = (9'd2 << idx) - 9'd1;
        return full[7:0];
    endfunction

    // crossfade wait, 160 divided by the level of each index
    function automatic logic [7:0] fade_wait_of(input logic [2:0] idx);
        logic [7:0] ticks;
        case (idx)
            3'd0:    ticks = 8'd160;
            3'd1:    ticks = 8'd53;
            3'd2:    ticks = 8'd22;
            3'd3:    ticks = 8'd10;
            3'd4:    ticks = 8'd5;
            3'd5:    ticks = 8'd2;
            3'd6:    ticks = 8'd1;
            default: ticks = 8'd0;
        endcase
        return ticks;
    endfunction

endpackage

// File: src/sled_core.sv
// ----------------------------------------------------------------------------
// sled_core
// Pattern state and the single-pass update for one beat: brightness steps,
// mode selection, wait countdown and the mode action.
// ----------------------------------------------------------------------------
module sled_core #(
    parameter int MAX_LEVEL_INDEX = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sled_pkg::item_t   item,
    output sled_pkg::result_t result
);
    import sled_pkg::*;

    localparam logic [2:0] MAX_IDX = 3'(MAX_LEVEL_INDEX);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_RED   = 2'd1,
        PH_GREEN = 2'd2,
        PH_BLUE  = 2'd3
    } phase_t;

    logic [3:0]  mode_reg,         mode_next;
    logic [2:0]  level_index_reg,  level_index_next;
    logic [7:0]  fade_level_reg,   fade_level_next;
    phase_t      fade_phase_reg,   fade_phase_next;
    logic        blink_phase_reg,  blink_phase_next;
    logic [7:0]  wait_ticks_reg,   wait_ticks_next;
    logic        wait_forever_reg, wait_forever_next;
    logic        caps_reg,         caps_next;
    logic [23:0] colour_reg,       colour_next;

    logic        run;
    logic        refresh;
    logic [7:0]  level;
    logic [7:0]  rest;
    logic [7:0]  fade_inc;

    always_comb
    begin
        mode_next         = mode_reg;
        level_index_next  = level_index_reg;
        fade_level_next   = fade_level_reg;
        fade_phase_next   = fade_phase_reg;
        blink_phase_next  = blink_phase_reg;
        wait_ticks_next   = wait_ticks_reg;
        wait_forever_next = wait_forever_reg;
        caps_next         = caps_reg;
        colour_next       = colour_reg;
        run               = 1'b0;
        refresh           = 1'b0;

        if (item.operation == OP_COMMAND) begin
            if (item.command == CMD_BRIGHTER || item.command == CMD_DIMMER) begin
                if (item.command == CMD_BRIGHTER && level_index_reg < MAX_IDX) begin
                    level_index_next = level_index_reg + 3'd1;
                end
                else if (item.command == CMD_DIMMER && level_index_reg != 3'd0) begin
                    level_index_next = level_index_reg - 3'd1;
                end
                fade_level_next = 8'd0;
            end
            else begin
                mode_next = item.command;
            end
            run = 1'b1;
        end
        else if (!wait_forever_reg) begin
            if (wait_ticks_reg <= 8'd1) begin
                run = 1'b1;
            end
            else begin
                wait_ticks_next = wait_ticks_reg - 8'd1;
            end
        end

        level    = level_of(level_index_next);
        rest     = level - fade_level_next;
        fade_inc = fade_level_next + 8'd1;

        if (run) begin
            refresh           = 1'b1;
            wait_ticks_next   = 8'd0;
            wait_forever_next = 1'b1;
            unique case (mode_next)
                MODE_CAPS_USB:
                begin
                    colour_next = {level, level, 8'd0};
                    caps_next   = 1'b1;
                end
                MODE_CAPS_BLE:
                begin
                    colour_next = {level, 8'd0, level};
                    caps_next   = 1'b1;
                end
                MODE_USB:
                begin
                    colour_next = {8'd0, level, 8'd0};
                    caps_next   = 1'b0;
                end
                MODE_BT_SEARCH:
                begin
                    colour_next       = blink_phase_reg ? {16'd0, level} : {level, 16'd0};
                    blink_phase_next  = ~blink_phase_reg;
                    caps_next         = 1'b0;
                    wait_ticks_next   = BLINK_TICKS;
                    wait_forever_next = 1'b0;
                end
                MODE_BT_CONN:
                begin
                    colour_next = {16'd0, level};
                    caps_next   = 1'b0;
                end
                MODE_RAINBOW:
                begin
                    unique case (fade_phase_reg)
                        PH_START: colour_next = {fade_level_next, 16'd0};
                        PH_RED:   colour_next = {rest, fade_level_next, 8'd0};
                        PH_GREEN: colour_next = {8'd0, rest, fade_level_next};
                        default:  colour_next = {fade_level_next, 8'd0, rest};
                    endcase
                    if (fade_inc >= level) begin
                        unique case (fade_phase_reg)
                            PH_START: fade_phase_next = PH_RED;
                            PH_RED:   fade_phase_next = PH_GREEN;
                            PH_GREEN: fade_phase_next = PH_BLUE;
                            default:  fade_phase_next = PH_RED;
                        endcase
                        fade_level_next = 8'd0;
                    end
                    else begin
                        fade_level_next = fade_inc;
                    end
                    wait_ticks_next   = fade_wait_of(level_index_next);
                    wait_forever_next = 1'b0;
                end
                MODE_ERROR:
                begin
                    colour_next = {8'd0, level, 8'd0};
                end
                default:
                begin
                    // unknown mode leaves pixel and lamp alone
                    refresh = 1'b0;
                end
            endcase
        end
    end

    assign result.red           = colour_next[23:16];
    assign result.green         = colour_next[15:8];
    assign result.blue          = colour_next[7:0];
    assign result.caps_lamp_on  = caps_next;
    assign result.pixel_refresh = refresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= MODE_RAINBOW;
            level_index_reg  <= LEVEL_INDEX_RESET;
            fade_level_reg   <= 8'd0;
            fade_phase_reg   <= PH_START;
            blink_phase_reg  <= 1'b0;
            wait_ticks_reg   <= 8'd0;
            wait_forever_reg <= 1'b0;
            caps_reg         <= 1'b0;
            colour_reg       <= 24'd0;
        end
        else if (fire) begin
            mode_reg         <= mode_next;
            level_index_reg  <= level_index_next;
            fade_level_reg   <= fade_level_next;
            fade_phase_reg   <= fade_phase_next;
            blink_phase_reg  <= blink_phase_next;
            wait_ticks_reg   <= wait_ticks_next;
            wait_forever_reg <= wait_forever_next;
            caps_reg         <= caps_next;
            colour_reg       <= colour_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_index_limit: assert property (@(posedge clk) disable iff (!rst_n)
        level_index_reg <= MAX_IDX)
        else $error("brightness index beyond limit");

    a_fade_below_level: assert property (@(posedge clk) disable iff (!rst_n)
        fade_level_reg < level_of(level_index_reg))
        else $error("fade level reached brightness level");

    a_forever_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        wait_forever_reg |-> wait_ticks_reg == 8'd0)
        else $error("wait forever with a pending tick count");
`endif

endmodule

// File: src/status_led_pattern_controller.sv
// ----------------------------------------------------------------------------
// status_led_pattern_controller
// Status pixel and caps lamp pattern controller with registered input and
// result stages around a single-pass pattern update.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall    sled_pkg::item_t
//   result   out        result_valid / result_stall sled_pkg::result_t
//
// one beat per cycle sustained while result_stall is low; a taken beat is held in
// the item register, is then loaded into the result register and leaves from there
// every item gives exactly one result beat
// reset clears pattern state to rainbow at index 2 with a dark pixel
// result_stall holds the result register and backs up into item_stall
// ----------------------------------------------------------------------------
module status_led_pattern_controller #(
    parameter int MAX_LEVEL_INDEX = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  sled_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output sled_pkg::result_t result
);
    import sled_pkg::*;

    logic    item_vld_reg;
    item_t   item_reg;
    logic    result_vld_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;
    logic    fire;
    logic    take;

    // result register free or being drained this cycle
    assign advance    = !result_vld_reg || !result_stall;
    assign fire       = item_vld_reg && advance;
    assign item_stall = item_vld_reg && !advance;
    assign take       = item_valid && !item_stall;

    sled_core #(
        .MAX_LEVEL_INDEX (MAX_LEVEL_INDEX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance || !item_vld_reg)
            begin
                item_vld_reg <= item_valid;
            end
            if (advance)
            begin
                result_vld_reg <= item_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_vld_reg && result_vld_reg)
        else $error("input stalled with room in the pipeline");

    a_beat_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_vld_reg)
        else $error("updated beat missing from result register");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_vld_reg && !result_stall && !item_vld_reg) |=> !result_vld_reg)
        else $error("result repeated after drain");
`endif

endmodule

// File: bench/sled_pixel_checker.sv
// ----------------------------------------------------------------------------
// sled_pixel_checker
// Watches the item and result channels of the status pixel controller, keeps
// its own model of the pattern state, and compares every result beat with the
// oldest predicted pixel. Mismatch and progress counts go back to the bench.
// ----------------------------------------------------------------------------
module sled_pixel_checker #(
    parameter int MAX_LEVEL_INDEX = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  sled_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  sled_pkg::result_t result,
    output int                errors,
    output int                pending,
    output int                checked,
    output int                refreshes
);
    timeunit 1ns;
    timeprecision 1ps;

    import sled_pkg::*;

    typedef enum logic [1:0] {
        FADE_START,
        FADE_RED,
        FADE_GREEN,
        FADE_BLUE
    } fade_step_t;

    // model of the pattern state
    logic [3:0] mode_q;
    logic [2:0] level_idx;
    logic [7:0] ramp;
    fade_step_t fade_step;
    logic       blink_blue;
    logic [7:0] ticks_left;
    logic       parked;
    logic       lamp;
    logic [7:0] px_r;
    logic [7:0] px_g;
    logic [7:0] px_b;

    result_t expected_pixels[$];
    int      err_cnt;
    int      beat_cnt;
    int      refresh_cnt;
    int      report_cnt;

    function automatic void paint(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
        px_r = r;
        px_g = g;
        px_b = b;
    endfunction

    // runs the current mode once, returns 1 when the pixel was resent
    function automatic logic run_pattern();
        logic [7:0] lvl;
        logic [7:0] rest;
        logic       shown;
        lvl = 8'hFF >> (3'd7 - level_idx);
        rest = lvl - ramp;
        shown = 1'b1;
        parked = 1'b1;
        ticks_left = '0;
        case (mode_q)
            MODE_CAPS_USB:
            begin
                paint(lvl, lvl, 8'd0);
                lamp = 1'b1;
            end
            MODE_CAPS_BLE:
            begin
                paint(lvl, 8'd0, lvl);
                lamp = 1'b1;
            end
            MODE_USB:
            begin
                paint(8'd0, lvl, 8'd0);
                lamp = 1'b0;
            end
            MODE_BT_SEARCH:
            begin
                if (blink_blue)
                    paint(8'd0, 8'd0, lvl);
                else
                    paint(lvl, 8'd0, 8'd0);
                blink_blue = ~blink_blue;
                lamp = 1'b0;
                parked = 1'b0;
                ticks_left = BLINK_TICKS;
            end
            MODE_BT_CONN:
            begin
                paint(8'd0, 8'd0, lvl);
                lamp = 1'b0;
            end
            MODE_RAINBOW:
            begin
                case (fade_step)
                    FADE_START: paint(ramp, 8'd0, 8'd0);
                    FADE_RED:   paint(rest, ramp, 8'd0);
                    FADE_GREEN: paint(8'd0, rest, ramp);
                    default:    paint(ramp, 8'd0, rest);
                endcase
                ramp = ramp + 8'd1;
                if (ramp >= lvl)
                begin
                    case (fade_step)
                        FADE_START: fade_step = FADE_RED;
                        FADE_RED:   fade_step = FADE_GREEN;
                        FADE_GREEN: fade_step = FADE_BLUE;
                        default:    fade_step = FADE_RED;
                    endcase
                    ramp = '0;
                end
                parked = 1'b0;
                ticks_left = 8'(32'd160 / 32'(lvl));
            end
            MODE_ERROR:
            begin
                paint(8'd0, lvl, 8'd0);
            end
            default:
            begin
                // unknown mode: pixel and lamp left alone
                shown = 1'b0;
            end
        endcase
        return shown;
    endfunction

    function automatic result_t step_pattern(input item_t it);
        result_t r;
        logic    refreshed;
        refreshed = 1'b0;
        if (it.operation == OP_COMMAND)
        begin
            if (it.command == CMD_BRIGHTER || it.command == CMD_DIMMER)
            begin
                if (it.command == CMD_BRIGHTER && level_idx < MAX_LEVEL_INDEX)
                    level_idx = level_idx + 3'd1;
                else if (it.command == CMD_DIMMER && level_idx > 3'd0)
                    level_idx = level_idx - 3'd1;
                ramp = '0;
            end
            else
            begin
                mode_q = it.command;
            end
            refreshed = run_pattern();
        end
        else if (!parked)
        begin
            if (ticks_left <= 8'd1)
                refreshed = run_pattern();
            else
                ticks_left = ticks_left - 8'd1;
        end
        r.red = px_r;
        r.green = px_g;
        r.blue = px_b;
        r.caps_lamp_on = lamp;
        r.pixel_refresh = refreshed;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    bad;
        if (!rst_n)
        begin
            mode_q = MODE_RAINBOW;
            level_idx = LEVEL_INDEX_RESET;
            ramp = '0;
            fade_step = FADE_START;
            blink_blue = 1'b0;
            ticks_left = '0;
            parked = 1'b0;
            lamp = 1'b0;
            paint(8'd0, 8'd0, 8'd0);
            expected_pixels.delete();
            err_cnt = 0;
            beat_cnt = 0;
            refresh_cnt = 0;
            report_cnt = 0;
            errors <= 0;
            pending <= 0;
            checked <= 0;
            refreshes <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_pixels.push_back(step_pattern(item));
            if (result_valid && !result_stall)
            begin
                beat_cnt++;
                if (result.pixel_refresh)
                    refresh_cnt++;
                if (expected_pixels.size() == 0)
                begin
                    err_cnt++;
                    if (report_cnt < 10)
                    begin
                        report_cnt++;
                        $display("result beat %0d arrived with nothing expected: %p",
                                 beat_cnt, result);
                    end
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    bad = (result.red !== want.red) || (result.green !== want.green)
                        || (result.blue !== want.blue)
                        || (result.caps_lamp_on !== want.caps_lamp_on)
                        || (result.pixel_refresh !== want.pixel_refresh);
                    if (bad)
                    begin
                        err_cnt++;
                        if (report_cnt < 10)
                        begin
                            report_cnt++;
                            $display("beat %0d: expected rgb %02h %02h %02h lamp %0b refresh %0b",
                                     beat_cnt, want.red, want.green, want.blue,
                                     want.caps_lamp_on, want.pixel_refresh);
                            $display("beat %0d:      got rgb %02h %02h %02h lamp %0b refresh %0b",
                                     beat_cnt, result.red, result.green, result.blue,
                                     result.caps_lamp_on, result.pixel_refresh);
                        end
                    end
                end
            end
            errors <= err_cnt;
            pending <= expected_pixels.size();
            checked <= beat_cnt;
            refreshes <= refresh_cnt;
        end
    end

endmodule

// File: bench/status_led_pattern_controller_tb.sv
// ----------------------------------------------------------------------------
// status_led_pattern_controller_tb
// Drives ticks and commands into the status pixel controller: a directed pass
// over every mode, unknown codes and brightness clamping, then random command
// scenes followed by tick runs, with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
module status_led_pattern_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sled_pkg::*;

    localparam int RANDOM_BEATS     = 1300;
    localparam int CALM_TAIL        = 150;
    localparam int HOLD_AT_BEAT     = 400;
    localparam int LONG_HOLD_CYCLES = 90;
    localparam int CYCLE_LIMIT      = 400000;

    localparam logic [3:0] CMD_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int errors;
    int pending;
    int checked;
    int refreshes;

    int   beats_sent;
    int   ticks_sent;
    int   commands_sent;
    int   steps_sent;
    int   stall_cycles;
    int   cycle_count;
    int   gap_rate;
    logic calm;
    logic hold_done;

    status_led_pattern_controller i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    sled_pixel_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .refreshes    (refreshes)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // offers one beat, maybe after an idle burst, and returns once it is taken
    task automatic offer(input logic op, input logic [3:0] cmd);
        item_t it;
        int    gap;
        it.operation = op;
        it.command = cmd;
        if (!calm && gap_rate != 0 && $urandom_range(0, 7) < gap_rate)
        begin
            gap = $urandom_range(1, 14);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        beats_sent++;
        if (op == OP_TICK)
            ticks_sent++;
        else
            commands_sent++;
        if (op == OP_COMMAND && (cmd == CMD_BRIGHTER || cmd == CMD_DIMMER))
            steps_sent++;
    endtask

    always @(posedge clk)
    begin
        if (item_valid && item_stall)
            stall_cycles++;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall bursts, quiet stretches, one long hold
    initial
    begin
        result_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && beats_sent >= HOLD_AT_BEAT)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8))
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        int         directed_beats;
        int         pick;
        int         sel;
        int         span;
        logic [3:0] code;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        calm = 1'b0;
        gap_rate = 1;
        beats_sent = 0;
        ticks_sent = 0;
        commands_sent = 0;
        steps_sent = 0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first tick runs the rainbow, the next one only counts down
        offer(OP_TICK, 4'($urandom_range(0, 15)));
        offer(OP_TICK, 4'($urandom_range(0, 15)));
        offer(OP_COMMAND, MODE_CAPS_USB);
        // tick while parked forever
        offer(OP_TICK, 4'($urandom_range(0, 15)));
        offer(OP_COMMAND, MODE_CAPS_BLE);
        offer(OP_COMMAND, MODE_USB);
        offer(OP_COMMAND, MODE_BT_SEARCH);
        offer(OP_COMMAND, MODE_BT_CONN);
        offer(OP_COMMAND, MODE_ERROR);
        offer(OP_COMMAND, CMD_UNKNOWN_LO);
        offer(OP_COMMAND, CMD_UNKNOWN_HI);
        offer(OP_COMMAND, MODE_RAINBOW);
        offer(OP_TICK, 4'($urandom_range(0, 15)));
        // dim past the bottom, then tick the slowest fade
        repeat (3) offer(OP_COMMAND, CMD_DIMMER);
        offer(OP_TICK, 4'($urandom_range(0, 15)));
        // brighten past the top, fade then runs every tick
        repeat (8) offer(OP_COMMAND, CMD_BRIGHTER);
        offer(OP_TICK, 4'($urandom_range(0, 15)));
        directed_beats = beats_sent;

        while (beats_sent - directed_beats < RANDOM_BEATS)
        begin
            gap_rate = $urandom_range(0, 3);
            calm = (beats_sent - directed_beats >= RANDOM_BEATS - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                // noise: arbitrary beats
                repeat ($urandom_range(1, 10))
                    offer(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end
            else
            begin
                if (pick < 30)
                begin
                    repeat ($urandom_range(1, 4))
                        offer(OP_COMMAND, $urandom_range(0, 1) ? CMD_BRIGHTER : CMD_DIMMER);
                end
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 30)
                        code = MODE_RAINBOW;
                    else if (sel < 55)
                        code = MODE_BT_SEARCH;
                    else if (sel < 85)
                        code = 4'($urandom_range(0, 6));
                    else
                        code = 4'($urandom_range(0, 15));
                    offer(OP_COMMAND, code);
                end
                // tick run long enough at times to reach a blink toggle
                sel = $urandom_range(0, 19);
                if (sel < 5)
                    span = 0;
                else if (sel < 15)
                    span = $urandom_range(1, 20);
                else if (sel < 19)
                    span = $urandom_range(40, 120);
                else
                    span = $urandom_range(250, 520);
                // keep the run near its item budget
                if (span > RANDOM_BEATS - (beats_sent - directed_beats))
                    span = RANDOM_BEATS - (beats_sent - directed_beats);
                repeat (span)
                begin
                    calm = (beats_sent - directed_beats >= RANDOM_BEATS - CALM_TAIL);
                    offer(OP_TICK, 4'($urandom_range(0, 15)));
                end
            end
        end
        item_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("stimulus: %0d ticks, %0d commands (%0d brightness steps), %0d input stall cycles",
                 ticks_sent, commands_sent, steps_sent, stall_cycles);
        $display("checked %0d result beats, %0d of them pixel refreshes", checked, refreshes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
